// ===== rtl/sbda_pkg.sv =====
// ----------------------------------------------------------------------------
// sbda_pkg: shared types and constants
// Character codes, reciprocal constant for the divide by ten, and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package sbda_pkg;

	localparam int VALUE_W   = 32;
	localparam int CHAR_W    = 6;
	localparam int DIGIT_W   = 4;
	localparam int MAX_DIGITS = 10;
	localparam int CNT_W     = $clog2(MAX_DIGITS + 1);

	// floor(x / 10) == (x * RECIP_TEN) >> RECIP_SHIFT for every 32-bit x
	localparam logic [VALUE_W-1:0] RECIP_TEN   = 32'hCCCC_CCCD;
	localparam int                 RECIP_SHIFT = 35;
	localparam int                 QUOT_W      = 2 * VALUE_W - RECIP_SHIFT;

	typedef logic [VALUE_W-1:0] value_t;
	typedef logic [CHAR_W-1:0]  char_t;
	typedef logic [DIGIT_W-1:0] digit_t;
	typedef logic [CNT_W-1:0]   cnt_t;

	localparam char_t CHAR_MINUS = 6'd45;
	localparam char_t CHAR_ZERO  = 6'd48;
	localparam char_t CHAR_NINE  = 6'd57;

	typedef struct packed {
		logic load;        // capture a new value
		logic step;        // peel off one digit
		logic emit_sign;   // write '-' to the output register
		logic emit_digit;  // write the leading stored digit
	} sbda_cmd_t;

	typedef struct packed {
		logic mag_last;    // remaining magnitude is below ten
		logic neg;         // current value is negative
		logic out_free;    // output register can take a character
		logic one_left;    // one stored digit remains
	} sbda_status_t;

endpackage

// ===== rtl/sbda_value_if.sv =====
// ----------------------------------------------------------------------------
// sbda_value_if: input channel
// Valid/ready channel carrying one signed 32-bit value per transfer.
// ----------------------------------------------------------------------------
interface sbda_value_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

// ===== rtl/sbda_char_if.sv =====
// ----------------------------------------------------------------------------
// sbda_char_if: output channel
// Valid/ready channel carrying one ASCII character and an end-of-text flag.
// ----------------------------------------------------------------------------
interface sbda_char_if;
	logic       valid;
	logic       ready;
	logic [5:0] ascii_char;
	logic       last;

	modport source (output valid, output ascii_char, output last, input ready);
	modport sink   (input valid, input ascii_char, input last, output ready);
endinterface

// ===== rtl/sbda_datapath.sv =====
// ----------------------------------------------------------------------------
// sbda_datapath: magnitude, digit stack and output register
// Divides the magnitude by ten once per step through a reciprocal multiply,
// stacks the digits and pops them most significant first.
// ----------------------------------------------------------------------------
module sbda_datapath import sbda_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  sbda_cmd_t    cmd,
	output sbda_status_t status,
	input  value_t       value,
	input  logic         out_ready,
	output logic         out_valid,
	output char_t        out_char,
	output logic         out_last
);

	value_t                  mag_q;
	logic                    neg_q;
	cnt_t                    ndig_q;
	digit_t                  digits_q [MAX_DIGITS];
	logic                    out_valid_q;
	char_t                   out_char_q;
	logic                    out_last_q;

	logic [2*VALUE_W-1:0]    prod;
	logic [QUOT_W-1:0]       quot;
	digit_t                  ten_lo;
	digit_t                  digit;
	value_t                  abs_in;

	assign prod   = {{VALUE_W{1'b0}}, mag_q} * {{VALUE_W{1'b0}}, RECIP_TEN};
	assign quot   = prod[2*VALUE_W-1:RECIP_SHIFT];
	// low nibble of quot * 10; the remainder fits in four bits
	assign ten_lo = {quot[0], 3'b000} + {quot[2:0], 1'b0};
	assign digit  = mag_q[DIGIT_W-1:0] - ten_lo;
	assign abs_in = value[VALUE_W-1] ? (~value + value_t'(1)) : value;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mag_q <= abs_in;
			neg_q <= value[VALUE_W-1];
		end else if (cmd.step) begin
			mag_q <= value_t'(quot);
		end
		if (cmd.step) begin
			digits_q[0] <= digit;
			for (int i = 1; i < MAX_DIGITS; i++) digits_q[i] <= digits_q[i-1];
		end else if (cmd.emit_digit) begin
			for (int i = 0; i < MAX_DIGITS - 1; i++) digits_q[i] <= digits_q[i+1];
			digits_q[MAX_DIGITS-1] <= '0;
		end
		if (cmd.emit_sign) begin
			out_char_q <= CHAR_MINUS;
			out_last_q <= 1'b0;
		end else if (cmd.emit_digit) begin
			out_char_q <= CHAR_ZERO + char_t'(digits_q[0]);
			out_last_q <= (ndig_q == cnt_t'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ndig_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) ndig_q <= '0;
			else if (cmd.step) ndig_q <= ndig_q + cnt_t'(1);
			else if (cmd.emit_digit) ndig_q <= ndig_q - cnt_t'(1);
			if (cmd.emit_sign || cmd.emit_digit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign status.mag_last = (quot == '0);
	assign status.neg      = neg_q;
	assign status.out_free = !out_valid_q || out_ready;
	assign status.one_left = (ndig_q == cnt_t'(1));

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign out_last  = out_last_q;

endmodule

// ===== rtl/sbda_ctrl.sv =====
// ----------------------------------------------------------------------------
// sbda_ctrl: sequencing state machine
// Accepts a value, runs the digit steps, then emits the sign, if negative, and the digits.
// ----------------------------------------------------------------------------
module sbda_ctrl import sbda_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  sbda_status_t status,
	output sbda_cmd_t    cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SIGN,
		ST_DIGS
	} state_t;

	state_t state_q;
	logic   in_ready_q;

	always_comb begin
		cmd            = '0;
		cmd.load       = in_ready_q && in_valid;
		cmd.step       = (state_q == ST_CONV);
		cmd.emit_sign  = (state_q == ST_SIGN) && status.out_free;
		cmd.emit_digit = (state_q == ST_DIGS) && status.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			in_ready_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					in_ready_q <= 1'b1;
					if (in_ready_q && in_valid) begin
						state_q    <= ST_CONV;
						in_ready_q <= 1'b0;
					end
				end
				ST_CONV: begin
					if (status.mag_last) state_q <= status.neg ? ST_SIGN : ST_DIGS;
				end
				ST_SIGN: begin
					if (status.out_free) state_q <= ST_DIGS;
				end
				ST_DIGS: begin
					if (status.out_free && status.one_left) begin
						state_q    <= ST_IDLE;
						in_ready_q <= 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready = in_ready_q;

endmodule

// ===== rtl/signed_binary_to_decimal_ascii_core.sv =====
// ----------------------------------------------------------------------------
// signed_binary_to_decimal_ascii_core: signed 32-bit to decimal text
// Usage:
//   num  (sink)   one signed 32-bit value per transfer.
//   txt  (source) one ASCII character per transfer; last marks the final
//                 character of a number. A negative value starts with '-',
//                 digits follow most significant first, no leading zeros.
// Sequence, for a value with n decimal digits (1..10), s = 1 if negative:
//   the value is taken, then n divide-by-ten steps run (one
//   reciprocal multiply per digit), then n + s characters are sent.
//   First character is loaded into the output register after the final
//   step, and the block holds one item at a time. The next value is
//   taken while the final character still sits in the output register.
// Reset: arst_n clears the controller, the digit count and output valid;
//   nothing else carries over between numbers.
// Stall: when txt.ready is low the held character stays put and the
//   sequencer waits; num.ready stays low until the final character has
//   been loaded into the output register.
// ----------------------------------------------------------------------------
module signed_binary_to_decimal_ascii_core import sbda_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	sbda_value_if.sink    num,
	sbda_char_if.source   txt
);

	sbda_cmd_t    cmd;
	sbda_status_t status;
	logic         in_ready;
	logic         out_valid;
	char_t        out_char;
	logic         out_last;

	// sequencer: owns the input handshake and issues datapath commands
	sbda_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (num.valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	// datapath: magnitude, digit stack, output register
	sbda_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.value     (value_t'(num.value)),
		.out_ready (txt.ready),
		.out_valid (out_valid),
		.out_char  (out_char),
		.out_last  (out_last)
	);

	assign num.ready      = in_ready;
	assign txt.valid      = out_valid;
	assign txt.ascii_char = out_char;
	assign txt.last       = out_last;

endmodule

// ===== rtl/sbda_checker.sv =====
// ----------------------------------------------------------------------------
// sbda_checker: port-level assertions
// Watches the top-level channels; attached by bind.
// ----------------------------------------------------------------------------
module sbda_checker import sbda_pkg::*; (
	input logic  clk,
	input logic  arst_n,
	input logic  in_valid,
	input logic  in_ready,
	input logic  out_valid,
	input logic  out_ready,
	input char_t out_char,
	input logic  out_last
);

	// a held character does not change while stalled
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(out_last))
		else $error("output changed while stalled");

	// every character is a minus sign or a decimal digit
	a_char_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_char == CHAR_MINUS ||
			(out_char >= CHAR_ZERO && out_char <= CHAR_NINE)))
		else $error("character code out of range");

	// a minus sign never ends a number
	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_char == CHAR_MINUS |-> !out_last)
		else $error("minus sign flagged as last");

	// after taking a value the input closes while that value is converted
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input reopened right after a transfer");

endmodule

bind signed_binary_to_decimal_ascii_core sbda_checker u_sbda_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (num.valid),
	.in_ready  (num.ready),
	.out_valid (txt.valid),
	.out_ready (txt.ready),
	.out_char  (txt.ascii_char),
	.out_last  (txt.last)
);

// ===== verif/sbda_text_checker.sv =====
// ----------------------------------------------------------------------------
// sbda_text_checker: scoreboard for the decimal text converter
// Watches both channels. Each accepted value is expanded into its expected
// characters, and each accepted character is compared with the oldest one.
// ----------------------------------------------------------------------------
module sbda_text_checker import sbda_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	sbda_value_if num,
	sbda_char_if  txt,
	output int    mismatches,
	output int    chars_outstanding,
	output int    chars_checked,
	output int    numbers_done
);

	typedef struct packed {
		char_t code;
		logic  last;
	} text_char_t;

	text_char_t text_q[$];
	int err_cnt  = 0;
	int pend_cnt = 0;
	int char_cnt = 0;
	int num_cnt  = 0;

	assign mismatches        = err_cnt;
	assign chars_outstanding = pend_cnt;
	assign chars_checked     = char_cnt;
	assign numbers_done      = num_cnt;

	// Sign first, then digits of the unsigned magnitude, most significant first.
	function automatic void queue_decimal_text(input value_t v);
		value_t     mag;
		digit_t     digs[$];
		text_char_t c;
		mag = v[VALUE_W-1] ? ~v + 1'b1 : v;
		do begin
			digs.push_front(digit_t'(mag % 10));
			mag = mag / 10;
		end while (mag != 0);
		if (v[VALUE_W-1]) begin
			c.code = CHAR_MINUS;
			c.last = 1'b0;
			text_q.push_back(c);
		end
		foreach (digs[i]) begin
			c.code = CHAR_ZERO + char_t'(digs[i]);
			c.last = (i == digs.size() - 1);
			text_q.push_back(c);
		end
	endfunction

	// Outputs are handled before inputs: a character accepted on this edge
	// can never belong to a value accepted on the same edge.
	always @(posedge clk) begin
		text_char_t want;
		if (arst_n) begin
			if (txt.valid && txt.ready) begin
				char_cnt++;
				if (text_q.size() == 0) begin
					err_cnt++;
					$display("%0t: unexpected character: expected none, got code %0d last %b",
						$time, txt.ascii_char, txt.last);
				end else begin
					want = text_q.pop_front();
					if (txt.ascii_char !== want.code || txt.last !== want.last) begin
						err_cnt++;
						$display("%0t: character mismatch: expected code %0d last %b, got code %0d last %b",
							$time, want.code, want.last, txt.ascii_char, txt.last);
					end
					if (want.last)
						num_cnt++;
				end
			end
			if (num.valid && num.ready)
				queue_decimal_text(value_t'(num.value));
			pend_cnt = text_q.size();
		end
	end

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench top for signed_binary_to_decimal_ascii_core
// Drives signed values into the converter with bursty timing, stalls the
// character output on changing patterns, and leaves checking to the
// scoreboard. Directed corner values first, then random values spread over
// every digit count and sign.
// ----------------------------------------------------------------------------
module tb;
	import sbda_pkg::*;

	// Receiver back-pressure patterns.
	typedef enum int {
		RX_ALWAYS,   // ready every cycle
		RX_COIN,     // ready half the time
		RX_SPARSE,   // ready about one cycle in four
		RX_PATTERN   // fixed repeating gaps
	} rx_mode_t;

	localparam int N_RANDOM   = 236;
	localparam int HOLD_AT    = 600;  // characters checked before the long hold-off
	localparam int HOLD_LEN   = 300;  // length of the long hold-off
	localparam int TAIL_WAIT  = 30;   // settling wait after the last character is checked

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	sbda_value_if num ();
	sbda_char_if  txt ();

	int mismatches;
	int chars_outstanding;
	int chars_checked;
	int numbers_done;
	int values_sent = 0;
	int negatives_sent = 0;

	// Powers of ten up to 10^9 for digit-count and boundary values.
	int unsigned pow10 [10] = '{1, 10, 100, 1000, 10000, 100000, 1000000,
		10000000, 100000000, 1000000000};

	signed_binary_to_decimal_ascii_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.num    (num),
		.txt    (txt)
	);

	sbda_text_checker chk (
		.clk               (clk),
		.arst_n            (arst_n),
		.num               (num),
		.txt               (txt),
		.mismatches        (mismatches),
		.chars_outstanding (chars_outstanding),
		.chars_checked     (chars_checked),
		.numbers_done      (numbers_done)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hard stop in case the converter hangs or drops a character.
	initial begin
		#2_000_000;
		$display("simulation failed");
		$finish;
	end

	// Mostly values of a chosen digit count with random sign; a share of
	// raw 32-bit words, powers of ten give or take one, and the most
	// negative value, whose magnitude only fits unsigned.
	function automatic value_t random_value();
		int unsigned lo;
		int unsigned hi;
		int unsigned m;
		int          n;
		case ($urandom_range(0, 19))
			0, 1, 2: begin
				return $urandom();
			end
			3: begin
				return 32'h8000_0000;
			end
			4, 5: begin
				n = $urandom_range(1, 9);
				m = pow10[n] + $urandom_range(0, 2) - 1;
			end
			default: begin
				n  = $urandom_range(1, 10);
				lo = (n == 1) ? 0 : pow10[n-1];
				hi = (n == 10) ? 32'h7FFF_FFFF : pow10[n] - 1;
				m  = $urandom_range(hi, lo);
			end
		endcase
		return $urandom_range(0, 1) ? value_t'(0) - m : m;
	endfunction

	// Called at a falling edge; returns at a falling edge with valid low.
	// Bursts of back-to-back offers, separated by random gaps. valid is
	// only lowered when the gap is nonzero.
	task automatic send_values(input value_t vals[$]);
		int burst;
		int gap;
		burst = 0;
		foreach (vals[i]) begin
			if (burst == 0) begin
				gap = $urandom_range(0, 6);
				if (gap != 0) begin
					num.valid <= 1'b0;
					repeat (gap) @(negedge clk);
				end
				burst = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 10);
			end
			num.valid <= 1'b1;
			num.value <= vals[i];
			do @(posedge clk); while (num.ready !== 1'b1);
			values_sent++;
			if (vals[i][VALUE_W-1])
				negatives_sent++;
			@(negedge clk);
			burst--;
		end
		num.valid <= 1'b0;
		@(negedge clk);
	endtask

	// Let every queued character come out before offering more.
	task automatic drain_text();
		wait (chars_outstanding == 0);
		@(negedge clk);
	endtask

	// Receiver: changing stall patterns, plus one long hold-off while the
	// sender keeps offering, so the converter fills and stalls its input.
	initial begin : receiver
		rx_mode_t mode;
		int       left;
		bit       held;
		mode = RX_ALWAYS;
		left = 0;
		held = 1'b0;
		txt.ready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (!held && chars_checked >= HOLD_AT) begin
				held = 1'b1;
				txt.ready <= 1'b0;
				repeat (HOLD_LEN) @(negedge clk);
			end
			if (left == 0) begin
				mode = rx_mode_t'($urandom_range(0, 3));
				left = $urandom_range(20, 120);
			end
			left--;
			case (mode)
				RX_ALWAYS:  txt.ready <= 1'b1;
				RX_COIN:    txt.ready <= 1'($urandom_range(0, 1));
				RX_SPARSE:  txt.ready <= ($urandom_range(0, 3) == 0);
				default:    txt.ready <= (left % 3 != 0);
			endcase
		end
	end

	initial begin : stimulus
		value_t vals[$];
		// Zero, single digits, several length boundaries, both extremes, the
		// most negative value, and alternating bit patterns.
		int directed[$] = '{0, 1, -1, 9, -9, 10, -10, 99, 100, -100, 12345, -67890,
			999999999, 1000000000, -1000000000, 1234567890, -1999999999,
			2147483647, -2147483647, int'(32'h8000_0000), int'(32'h5555_5555),
			int'(32'hAAAA_AAAA), int'(32'h7FFF_FFFE), -2};

		num.valid = 1'b0;
		num.value = '0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed[i])
			vals.push_back(value_t'(directed[i]));
		send_values(vals);
		drain_text();

		// Random part in two halves with a full drain in between, so the
		// converter also sees a value arrive on a completely idle pipe.
		vals.delete();
		repeat (N_RANDOM / 2)
			vals.push_back(random_value());
		send_values(vals);
		drain_text();

		vals.delete();
		repeat (N_RANDOM - N_RANDOM / 2)
			vals.push_back(random_value());
		send_values(vals);

		wait (chars_outstanding == 0);
		repeat (TAIL_WAIT) @(posedge clk);

		$display("Converted %0d values (%0d negative) into %0d characters,",
			values_sent, negatives_sent, chars_checked);
		$display("%0d texts completed; all digit counts, both signs, the most",
			numbers_done);
		$display("negative value and a long output stall were exercised.");
		if (mismatches == 0 && chars_outstanding == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
